/* rtl/ftt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_pkg
// Shared types and constants of the feature track table.
// ----------------------------------------------------------------------------
package ftt_pkg;

    localparam int CAPACITY  = 64;
    localparam int FRAC_BITS = 4;
    localparam int ID_SPAN   = 10000;

    localparam int COORD_W   = 16;
    localparam int ID_W      = 20;
    localparam int IDX_W     = 7;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam int BORDER_PX = 10;
    localparam int CORNER_PX = 60;
    localparam int WANT_NUM  = 8;
    localparam int WANT_DEN  = 10;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_FEATURES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPACING  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MOTION   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    localparam logic [6:0]  RST_MAX_FEATURES = 7'd50;
    localparam logic [11:0] RST_MIN_SPACING  = 12'd160;
    localparam logic [15:0] RST_MAX_MOTION   = 16'd480;
    localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd480;

    localparam logic [1:0] REQ_TRACK  = 2'd0;
    localparam logic [1:0] REQ_CAND   = 2'd1;
    localparam logic [1:0] REQ_PASS   = 2'd2;
    localparam logic [1:0] REQ_IGNORE = 2'd3;

    typedef struct packed {
        logic [1:0]                 req_type;
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
        logic signed [COORD_W-1:0]  back_x;
        logic signed [COORD_W-1:0]  back_y;
        logic                       fwd_ok;
        logic                       back_ok;
    } t_in;

    typedef struct packed {
        logic                       accepted;
        logic [ID_W-1:0]            entry_id;
        logic [IDX_W-1:0]           entry_index;
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic [IDX_W-1:0]           entry_count;
        logic                       want_new;
    } t_out;

    typedef struct packed {
        logic load_item;
        logic rd_en;
        logic rd_scan;
        logic scan_clr;
        logic scan_inc;
        logic track_eval;
        logic cand_write;
        logic pass_end;
        logic hit_clr;
        logic hit_prox;
        logic hit_id;
        logic id_next;
        logic step_clr;
        logic step_inc;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic tr_avail;
        logic cand_room;
        logic cand_skip;
        logic scan_last;
        logic pipe_busy;
        logic pipe_out;
        logic hit;
        logic div_busy;
        logic step_last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/feature_track_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feature_track_table
// Table of tracked image features with pruning, compaction and id handout.
// ----------------------------------------------------------------------------
// Usage:
//  input channel i_valid/o_ready carries one request (tracked entry, new
//  candidate or end of tracking pass); output channel o_valid/i_ready
//  returns exactly one result per request, in order.
//  One transaction is worked on at a time; o_ready is high only while idle.
//  Work per item (N = entries in the table):
//    tracked entry      one table read through the distance pipe
//    pass end           no table read
//    candidate          a scan of all N entries for spacing, then per id
//                       tried a scan of all N entries, plus a bitwise
//                       remainder when the id counter wraps; at most CAPACITY + 1 ids are tried
//  The single table read port, walked one entry per cycle, bounds this work.
//  The result register frees the input side: the next transaction is
//  taken while a finished result waits for i_ready; a new result waits
//  until the old one is taken.
//  Reset empties the table, zeroes the id counter, marks a cold start and
//  loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module feature_track_table #(
    parameter int CAPACITY  = ftt_pkg::CAPACITY,
    parameter int FRAC_BITS = ftt_pkg::FRAC_BITS,
    parameter int ID_SPAN   = ftt_pkg::ID_SPAN
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  ftt_pkg::t_in                   i_data,
    output logic                           o_valid,
    input  logic                           i_ready,
    output ftt_pkg::t_out                  o_data,
    input  logic                           i_cfg_we,
    input  logic [ftt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ftt_pkg::CFG_W-1:0]      i_cfg_data
);

    ftt_pkg::t_cmd  cmd;
    ftt_pkg::t_stat stat;

    ftt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_data.req_type),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_ready (o_ready)
    );

    ftt_datapath #(
        .CAPACITY  (CAPACITY),
        .FRAC_BITS (FRAC_BITS),
        .ID_SPAN   (ID_SPAN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item      (i_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_ready),
        .o_out_valid (o_valid),
        .o_out       (o_data)
    );

    // one transaction in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("new transaction taken while busy");

    // rejected results carry no entry
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.accepted) |->
        (o_data.entry_id == '0 && o_data.out_x == '0 && o_data.want_new == 1'b0))
        else $error("rejected result carries entry data");

    // table never grows past its storage
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (int'(o_data.entry_count) <= CAPACITY))
        else $error("entry count beyond capacity");

endmodule

/* rtl/ftt_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ftt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]          i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

/* rtl/ftt_dist.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_dist
// Three stage squared distance: difference, square, sum.
// ----------------------------------------------------------------------------
module ftt_dist (
    input  logic                              i_clk,
    input  logic signed [ftt_pkg::COORD_W-1:0] i_ax,
    input  logic signed [ftt_pkg::COORD_W-1:0] i_ay,
    input  logic signed [ftt_pkg::COORD_W-1:0] i_bx,
    input  logic signed [ftt_pkg::COORD_W-1:0] i_by,
    output logic [2*ftt_pkg::COORD_W+2:0]      o_d2
);

    localparam int DW = ftt_pkg::COORD_W + 1;

    logic signed [DW-1:0]   r_dx;
    logic signed [DW-1:0]   r_dy;
    logic signed [2*DW-1:0] r_sx;
    logic signed [2*DW-1:0] r_sy;

    always_ff @(posedge i_clk) begin
        r_dx <= DW'(i_ax) - DW'(i_bx);
        r_dy <= DW'(i_ay) - DW'(i_by);
        r_sx <= r_dx * r_dx;
        r_sy <= r_dy * r_dy;
        o_d2 <= (2*DW+1)'(unsigned'(r_sx)) + (2*DW+1)'(unsigned'(r_sy));
    end

endmodule

/* rtl/ftt_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_ctrl
// Sequencer for tracked, candidate and pass end transactions.
// ----------------------------------------------------------------------------
module ftt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [1:0]          i_req,
    input  ftt_pkg::t_stat      i_stat,
    output ftt_pkg::t_cmd       o_cmd,
    output logic                o_ready
);

    typedef enum logic [12:0] {
        ST_IDLE    = 13'b0000000000001,
        ST_T_RD    = 13'b0000000000010,
        ST_T_WAIT  = 13'b0000000000100,
        ST_C_CHK   = 13'b0000000001000,
        ST_C_SCAN  = 13'b0000000010000,
        ST_C_DRAIN = 13'b0000000100000,
        ST_C_WR    = 13'b0000001000000,
        ST_A_INC   = 13'b0000010000000,
        ST_A_DIV   = 13'b0000100000000,
        ST_A_SCAN  = 13'b0001000000000,
        ST_A_DRAIN = 13'b0010000000000,
        ST_PASS    = 13'b0100000000000,
        ST_DONE    = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_item = 1'b1;
                    unique case (i_req)
                        ftt_pkg::REQ_TRACK: n_state = ST_T_RD;
                        ftt_pkg::REQ_CAND:  n_state = ST_C_CHK;
                        ftt_pkg::REQ_PASS:  n_state = ST_PASS;
                        default:            n_state = ST_DONE;
                    endcase
                end
            end
            ST_T_RD: begin
                if (i_stat.tr_avail) begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = ST_T_WAIT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_T_WAIT: begin
                if (i_stat.pipe_out) begin
                    o_cmd.track_eval = 1'b1;
                    n_state          = ST_DONE;
                end
            end
            ST_C_CHK: begin
                if (!i_stat.cand_room) begin
                    n_state = ST_DONE;
                end else if (i_stat.cand_skip) begin
                    n_state = ST_C_WR;
                end else begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.hit_clr  = 1'b1;
                    n_state        = ST_C_SCAN;
                end
            end
            ST_C_SCAN: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_scan  = 1'b1;
                o_cmd.scan_inc = 1'b1;
                o_cmd.hit_prox = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_C_DRAIN;
                end
            end
            ST_C_DRAIN: begin
                o_cmd.hit_prox = 1'b1;
                if (!i_stat.pipe_busy) begin
                    n_state = i_stat.hit ? ST_DONE : ST_C_WR;
                end
            end
            ST_C_WR: begin
                o_cmd.cand_write = 1'b1;
                o_cmd.step_clr   = 1'b1;
                n_state          = ST_A_INC;
            end
            ST_A_INC: begin
                o_cmd.id_next = 1'b1;
                n_state       = ST_A_DIV;
            end
            ST_A_DIV: begin
                if (!i_stat.div_busy) begin
                    o_cmd.scan_clr = 1'b1;
                    o_cmd.hit_clr  = 1'b1;
                    n_state        = ST_A_SCAN;
                end
            end
            ST_A_SCAN: begin
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_scan  = 1'b1;
                o_cmd.scan_inc = 1'b1;
                o_cmd.hit_id   = 1'b1;
                if (i_stat.scan_last) begin
                    n_state = ST_A_DRAIN;
                end
            end
            ST_A_DRAIN: begin
                o_cmd.hit_id = 1'b1;
                if (!i_stat.pipe_busy) begin
                    if (i_stat.hit && !i_stat.step_last) begin
                        o_cmd.step_inc = 1'b1;
                        n_state        = ST_A_INC;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_PASS: begin
                o_cmd.pass_end = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

/* rtl/ftt_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftt_datapath
// Entry table, distance lanes, id search and output register.
// ----------------------------------------------------------------------------
module ftt_datapath #(
    parameter int CAPACITY  = ftt_pkg::CAPACITY,
    parameter int FRAC_BITS = ftt_pkg::FRAC_BITS,
    parameter int ID_SPAN   = ftt_pkg::ID_SPAN
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ftt_pkg::t_cmd                   i_cmd,
    output ftt_pkg::t_stat                  o_stat,
    input  ftt_pkg::t_in                    i_item,
    input  logic                            i_cfg_we,
    input  logic [ftt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ftt_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output ftt_pkg::t_out                   o_out
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int LIMW  = $clog2(CAPACITY + 1);
    localparam int SPANW = $clog2(ID_SPAN + 1);
    localparam int MODW  = LIMW + SPANW;
    localparam int CW    = ftt_pkg::COORD_W;
    localparam int IDW   = ftt_pkg::ID_W;
    localparam int IDXW  = ftt_pkg::IDX_W;
    localparam int DW    = 2 * CW + IDW;
    localparam int D2W   = 2 * CW + 3;
    localparam int DCW   = $clog2(IDW + 2);

    // configuration
    logic [6:0]  r_max_feat;
    logic [11:0] r_min_sp;
    logic [15:0] r_max_mot;
    logic [11:0] r_img_w;
    logic [11:0] r_img_h;

    // table state
    ftt_pkg::t_in    r_item;
    ftt_pkg::t_out   r_res;
    logic [LIMW-1:0] r_et;
    logic [LIMW-1:0] r_rd_slot;
    logic [LIMW-1:0] r_wr_slot;
    logic [IDW-1:0]  r_next_id;
    logic            r_cold;
    logic [LIMW-1:0] r_scan;
    logic [LIMW-1:0] r_step;
    logic [3:0]      r_v;
    logic            r_hit;

    // derived limits
    logic [23:0]     r_ms2;
    logic [31:0]     r_mm2;
    logic [MODW-1:0] r_mod;

    // remainder unit
    logic            r_div_busy;
    logic [DCW-1:0]  r_div_cnt;
    logic [IDW:0]    r_div_src;
    logic [MODW:0]   r_rem;

    logic [LIMW-1:0] lim;
    logic [LIMW-1:0] lim_nz;
    logic [DW-1:0]   rdata;
    logic signed [CW-1:0] rd_x;
    logic signed [CW-1:0] rd_y;
    logic [IDW-1:0]  rd_id;
    logic [D2W-1:0]  d2_mot;
    logic [D2W-1:0]  d2_back;
    logic            keep;
    logic            want;
    logic [IDW:0]    id_inc;
    logic [MODW:0]   rem_sh;
    logic [MODW:0]   rem_nx;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [AW-1:0]   ram_raddr;
    ftt_pkg::t_out   out_nx;

    assign lim    = (int'(r_max_feat) > CAPACITY) ? LIMW'(CAPACITY) : LIMW'(r_max_feat);
    assign lim_nz = (lim == '0) ? LIMW'(1) : lim;

    assign rd_x  = signed'(rdata[DW-1 -: CW]);
    assign rd_y  = signed'(rdata[DW-CW-1 -: CW]);
    assign rd_id = rdata[IDW-1:0];

    ftt_dist u_dist_mot (
        .i_clk (i_clk),
        .i_ax  (rd_x),
        .i_ay  (rd_y),
        .i_bx  (r_item.pos_x),
        .i_by  (r_item.pos_y),
        .o_d2  (d2_mot)
    );

    ftt_dist u_dist_back (
        .i_clk (i_clk),
        .i_ax  (rd_x),
        .i_ay  (rd_y),
        .i_bx  (r_item.back_x),
        .i_by  (r_item.back_y),
        .o_d2  (d2_back)
    );

    // keep test of a tracked entry
    always_comb begin
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] one;
        logic signed [31:0] wr;
        logic signed [31:0] hr;
        logic signed [31:0] xb;
        logic signed [31:0] yb;
        logic               border;
        logic               corner;
        logic               far;
        logic               bclose;
        px     = 32'(r_item.pos_x);
        py     = 32'(r_item.pos_y);
        one    = 32'sd1 << FRAC_BITS;
        wr     = signed'(32'(r_img_w) << FRAC_BITS) - px;
        hr     = signed'(32'(r_img_h) << FRAC_BITS) - py;
        xb     = (px < wr) ? px : wr;
        yb     = (py < hr) ? py : hr;
        border = (xb < one * ftt_pkg::BORDER_PX) || (yb < one * ftt_pkg::BORDER_PX);
        corner = (xb < one * ftt_pkg::CORNER_PX) && (yb < one * ftt_pkg::CORNER_PX);
        far    = d2_mot > D2W'(r_mm2);
        bclose = {d2_back, 2'b00} < ((D2W + 2)'(1) << (2 * FRAC_BITS));
        keep   = r_item.fwd_ok && r_item.back_ok && !far && !border && !corner
                 && bclose && (int'(r_wr_slot) < CAPACITY);
    end

    assign want = (r_et < lim) &&
                  (32'(r_et) * ftt_pkg::WANT_DEN <= 32'(lim) * ftt_pkg::WANT_NUM);

    assign id_inc = (IDW + 1)'(r_next_id) + 1'b1;
    assign rem_sh = {r_rem[MODW-1:0], r_div_src[IDW]};
    assign rem_nx = (rem_sh >= (MODW + 1)'(r_mod)) ? rem_sh - (MODW + 1)'(r_mod) : rem_sh;

    assign ram_we    = (i_cmd.track_eval && keep) || i_cmd.cand_write;
    assign ram_waddr = i_cmd.cand_write ? r_et[AW-1:0] : r_wr_slot[AW-1:0];
    assign ram_wdata = i_cmd.cand_write ? {r_item.pos_x, r_item.pos_y, r_next_id}
                                        : {r_item.pos_x, r_item.pos_y, rd_id};
    assign ram_raddr = i_cmd.rd_scan ? r_scan[AW-1:0] : r_rd_slot[AW-1:0];

    ftt_ram #(
        .WIDTH (DW),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_stat           = '0;
        o_stat.tr_avail  = r_rd_slot < r_et;
        o_stat.cand_room = r_et < lim;
        o_stat.cand_skip = r_cold || (r_et == '0);
        o_stat.scan_last = (r_scan + 1'b1) == r_et;
        o_stat.pipe_busy = |r_v;
        o_stat.pipe_out  = r_v[3];
        o_stat.hit       = r_hit;
        o_stat.div_busy  = r_div_busy;
        o_stat.step_last = r_step == LIMW'(CAPACITY);
        o_stat.out_free  = !o_out_valid || i_out_ready;
    end

    always_comb begin
        out_nx             = r_res;
        out_nx.entry_count = IDXW'(r_et);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_feat  <= ftt_pkg::RST_MAX_FEATURES;
            r_min_sp    <= ftt_pkg::RST_MIN_SPACING;
            r_max_mot   <= ftt_pkg::RST_MAX_MOTION;
            r_img_w     <= ftt_pkg::RST_IMAGE_WIDTH;
            r_img_h     <= ftt_pkg::RST_IMAGE_HEIGHT;
            r_et        <= '0;
            r_rd_slot   <= '0;
            r_wr_slot   <= '0;
            r_next_id   <= '0;
            r_cold      <= 1'b1;
            r_scan      <= '0;
            r_step      <= '0;
            r_v         <= '0;
            r_hit       <= 1'b0;
            r_div_busy  <= 1'b0;
            r_div_cnt   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ftt_pkg::REG_MAX_FEATURES: r_max_feat <= i_cfg_data[6:0];
                    ftt_pkg::REG_MIN_SPACING:  r_min_sp   <= i_cfg_data[11:0];
                    ftt_pkg::REG_MAX_MOTION:   r_max_mot  <= i_cfg_data[15:0];
                    ftt_pkg::REG_IMAGE_WIDTH:  r_img_w    <= i_cfg_data[11:0];
                    ftt_pkg::REG_IMAGE_HEIGHT: r_img_h    <= i_cfg_data[11:0];
                    default: ;
                endcase
            end

            r_v <= {r_v[2:0], i_cmd.rd_en};

            if (i_cmd.scan_clr) begin
                r_scan <= '0;
            end else if (i_cmd.scan_inc) begin
                r_scan <= r_scan + 1'b1;
            end

            if (i_cmd.step_clr) begin
                r_step <= '0;
            end else if (i_cmd.step_inc) begin
                r_step <= r_step + 1'b1;
            end

            if (i_cmd.hit_clr) begin
                r_hit <= 1'b0;
            end else if (i_cmd.hit_prox && r_v[3] && (d2_mot < D2W'(r_ms2))) begin
                r_hit <= 1'b1;
            end else if (i_cmd.hit_id && r_v[0] && (rd_id == r_next_id)) begin
                r_hit <= 1'b1;
            end

            if (i_cmd.track_eval) begin
                r_rd_slot <= r_rd_slot + 1'b1;
                if (keep) begin
                    r_wr_slot <= r_wr_slot + 1'b1;
                end
            end

            if (i_cmd.cand_write) begin
                r_et <= r_et + 1'b1;
            end

            if (i_cmd.pass_end) begin
                r_cold    <= (r_et == '0);
                r_et      <= r_wr_slot;
                r_rd_slot <= '0;
                r_wr_slot <= '0;
            end

            // next id: plain increment, or a bitwise remainder when it wraps
            if (i_cmd.id_next) begin
                if (32'(id_inc) < 32'(r_mod)) begin
                    r_next_id <= id_inc[IDW-1:0];
                end else begin
                    r_div_busy <= 1'b1;
                    r_div_cnt  <= DCW'(IDW + 1);
                end
            end else if (r_div_busy) begin
                r_div_cnt <= r_div_cnt - 1'b1;
                if (r_div_cnt == DCW'(1)) begin
                    r_div_busy <= 1'b0;
                    r_next_id  <= IDW'(rem_nx);
                end
            end

            if (i_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ms2 <= 24'(r_min_sp) * 24'(r_min_sp);
        r_mm2 <= 32'(r_max_mot) * 32'(r_max_mot);
        r_mod <= MODW'(lim_nz) * MODW'(ID_SPAN);

        if (i_cmd.id_next) begin
            r_div_src <= id_inc;
            r_rem     <= '0;
        end else if (r_div_busy) begin
            r_div_src <= {r_div_src[IDW-1:0], 1'b0};
            r_rem     <= rem_nx;
        end

        if (i_cmd.load_item) begin
            r_item <= i_item;
            r_res  <= '0;
        end

        if (i_cmd.track_eval && keep) begin
            r_res.accepted    <= 1'b1;
            r_res.entry_id    <= rd_id;
            r_res.entry_index <= IDXW'(r_wr_slot);
            r_res.out_x       <= r_item.pos_x;
            r_res.out_y       <= r_item.pos_y;
        end

        if (i_cmd.cand_write) begin
            r_res.accepted    <= 1'b1;
            r_res.entry_id    <= r_next_id;
            r_res.entry_index <= IDXW'(r_et);
            r_res.out_x       <= r_item.pos_x;
            r_res.out_y       <= r_item.pos_y;
        end

        if (i_cmd.pass_end) begin
            r_res.accepted <= 1'b1;
            r_res.want_new <= want;
        end

        if (i_cmd.out_load) begin
            o_out <= out_nx;
        end
    end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the feature track table: frames of tracked entries,
// pass ends and candidates under several register settings, with randomized
// input gaps and output stalls, checked against an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb_top;

    localparam longint CYCLE_LIMIT = 3000000;

    // predicts and checks results of the feature table
    class track_scoreboard;
        logic [6:0]  max_feat;
        logic [11:0] spacing;
        logic [15:0] motion;
        logic [11:0] img_w;
        logic [11:0] img_h;
        longint      x_tab[ftt_pkg::CAPACITY];
        longint      y_tab[ftt_pkg::CAPACITY];
        int unsigned id_tab[ftt_pkg::CAPACITY];
        int unsigned total, rd_slot, wr_slot, id_ctr;
        bit          cold;
        ftt_pkg::t_out pending[$];
        int          errors;

        function void clear();
            max_feat = ftt_pkg::RST_MAX_FEATURES;
            spacing  = ftt_pkg::RST_MIN_SPACING;
            motion   = ftt_pkg::RST_MAX_MOTION;
            img_w    = ftt_pkg::RST_IMAGE_WIDTH;
            img_h    = ftt_pkg::RST_IMAGE_HEIGHT;
            total = 0; rd_slot = 0; wr_slot = 0; id_ctr = 0; cold = 1;
            errors = 0;
        endfunction

        function void set_reg(logic [ftt_pkg::CFG_IDX_W-1:0] idx,
                              logic [ftt_pkg::CFG_W-1:0] val);
            case (idx)
                ftt_pkg::REG_MAX_FEATURES: max_feat = val[6:0];
                ftt_pkg::REG_MIN_SPACING:  spacing  = val[11:0];
                ftt_pkg::REG_MAX_MOTION:   motion   = val;
                ftt_pkg::REG_IMAGE_WIDTH:  img_w    = val[11:0];
                ftt_pkg::REG_IMAGE_HEIGHT: img_h    = val[11:0];
                default: ;
            endcase
        endfunction

        function int unsigned limit();
            return (max_feat > ftt_pkg::CAPACITY) ? ftt_pkg::CAPACITY : int'(max_feat);
        endfunction

        function longint sq_dist(longint ax, longint ay, longint bx, longint by);
            return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
        endfunction

        function void next_free_id(int unsigned count);
            int unsigned lim;
            int unsigned modv;
            bit          used;
            lim  = limit();
            modv = ((lim == 0) ? 1 : lim) * ftt_pkg::ID_SPAN;
            for (int s = 0; s < ftt_pkg::CAPACITY + 1; s++) begin
                id_ctr = (id_ctr + 1) % modv;
                used = 0;
                for (int i = 0; i < count && i < ftt_pkg::CAPACITY; i++)
                    if (id_tab[i] == id_ctr) used = 1;
                if (!used) break;
            end
        endfunction

        // accepted request: update the table and queue the expected result
        function void note_request(ftt_pkg::t_in req);
            ftt_pkg::t_out res;
            longint px, py, bx, by, sx, sy, one, xb, yb;
            bit     keep, add;
            int unsigned lim;
            px = req.pos_x; py = req.pos_y; bx = req.back_x; by = req.back_y;
            one = 1 << ftt_pkg::FRAC_BITS;
            lim = limit();
            res = '0;
            case (req.req_type)
                ftt_pkg::REQ_TRACK: begin
                    if (rd_slot < total && rd_slot < ftt_pkg::CAPACITY) begin
                        sx = x_tab[rd_slot]; sy = y_tab[rd_slot];
                        xb = (px < longint'(img_w) * one - px) ? px : longint'(img_w) * one - px;
                        yb = (py < longint'(img_h) * one - py) ? py : longint'(img_h) * one - py;
                        keep = req.fwd_ok && req.back_ok
                            && sq_dist(sx, sy, px, py) <= longint'(motion) * longint'(motion)
                            && !(xb < ftt_pkg::BORDER_PX * one || yb < ftt_pkg::BORDER_PX * one)
                            && !(xb < ftt_pkg::CORNER_PX * one && yb < ftt_pkg::CORNER_PX * one)
                            && 4 * sq_dist(sx, sy, bx, by)
                               < (longint'(1) << (2 * ftt_pkg::FRAC_BITS))
                            && wr_slot < ftt_pkg::CAPACITY;
                        if (keep) begin
                            x_tab[wr_slot] = px; y_tab[wr_slot] = py;
                            id_tab[wr_slot] = id_tab[rd_slot];
                            res.accepted = 1;
                            res.entry_id = ftt_pkg::ID_W'(id_tab[rd_slot]);
                            res.entry_index = ftt_pkg::IDX_W'(wr_slot);
                            res.out_x = req.pos_x; res.out_y = req.pos_y;
                            wr_slot++;
                        end
                        rd_slot++;
                    end
                end
                ftt_pkg::REQ_CAND: begin
                    add = total < lim && total < ftt_pkg::CAPACITY;
                    if (add && !cold)
                        for (int i = 0; i < total && i < ftt_pkg::CAPACITY; i++)
                            if (sq_dist(px, py, x_tab[i], y_tab[i])
                                < longint'(spacing) * longint'(spacing))
                                add = 0;
                    if (add) begin
                        x_tab[total] = px; y_tab[total] = py; id_tab[total] = id_ctr;
                        res.accepted = 1;
                        res.entry_id = ftt_pkg::ID_W'(id_ctr);
                        res.entry_index = ftt_pkg::IDX_W'(total);
                        res.out_x = req.pos_x; res.out_y = req.pos_y;
                        total++;
                        next_free_id(total);
                    end
                end
                ftt_pkg::REQ_PASS: begin
                    res.want_new = (total < lim && total <= 8 * lim / 10);
                    cold = (total == 0);
                    total = wr_slot;
                    rd_slot = 0; wr_slot = 0;
                    res.accepted = 1;
                end
                default: ;
            endcase
            res.entry_count = ftt_pkg::IDX_W'(total);
            pending = {pending, res};
        endfunction

        function void report(string name, longint exp_v, longint got_v);
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, got_v);
            errors++;
        endfunction

        function void check_result(ftt_pkg::t_out got);
            ftt_pkg::t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.accepted !== exp_r.accepted) report("accepted", exp_r.accepted, got.accepted);
            if (got.entry_id !== exp_r.entry_id) report("entry_id", exp_r.entry_id, got.entry_id);
            if (got.entry_index !== exp_r.entry_index)
                report("entry_index", exp_r.entry_index, got.entry_index);
            if (got.out_x !== exp_r.out_x) report("out_x", exp_r.out_x, got.out_x);
            if (got.out_y !== exp_r.out_y) report("out_y", exp_r.out_y, got.out_y);
            if (got.entry_count !== exp_r.entry_count)
                report("entry_count", exp_r.entry_count, got.entry_count);
            if (got.want_new !== exp_r.want_new) report("want_new", exp_r.want_new, got.want_new);
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    ftt_pkg::t_in  i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    ftt_pkg::t_out o_data;
    logic i_cfg_we = 0;
    logic [ftt_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [ftt_pkg::CFG_W-1:0]     i_cfg_data = '0;

    track_scoreboard sb;
    int     gap_pct = 0;
    int     stall_pct = 0;
    bit     hold_req = 0;
    int     hold_cnt = 0;
    int     sent = 0;
    longint cycles = 0;

    feature_track_table dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_data,
        .o_valid, .i_ready, .o_data, .i_cfg_we, .i_cfg_idx, .i_cfg_data
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random stalls plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (hold_cnt > 0) hold_cnt--;
        i_ready <= (hold_cnt == 0) && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);

    task automatic send(ftt_pkg::t_in req);
        i_valid <= 1;
        i_data  <= req;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(req);
        sent++;
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic ftt_pkg::t_in make_req(logic [1:0] kind, int px, int py, int bx, int by,
                                              bit fwd, bit bok);
        ftt_pkg::t_in r;
        r.req_type = kind;
        r.pos_x = 16'(px); r.pos_y = 16'(py); r.back_x = 16'(bx); r.back_y = 16'(by);
        r.fwd_ok = fwd; r.back_ok = bok;
        return r;
    endfunction

    function automatic ftt_pkg::t_in noise_req(logic [1:0] kind);
        ftt_pkg::t_in r;
        r = ftt_pkg::t_in'($bits(ftt_pkg::t_in)'({$urandom, $urandom, $urandom}));
        r.req_type = kind;
        return r;
    endfunction

    task automatic drain();
        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ftt_pkg::CFG_IDX_W-1:0] idx,
                             logic [ftt_pkg::CFG_W-1:0] val);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [6:0] mf, logic [11:0] sp, logic [15:0] mm,
                             logic [11:0] w, logic [11:0] h);
        drain();
        write_reg(ftt_pkg::REG_MAX_FEATURES, 16'(mf));
        write_reg(ftt_pkg::REG_MIN_SPACING, 16'(sp));
        write_reg(ftt_pkg::REG_MAX_MOTION, mm);
        write_reg(ftt_pkg::REG_IMAGE_WIDTH, 16'(w));
        write_reg(ftt_pkg::REG_IMAGE_HEIGHT, 16'(h));
        i_cfg_we <= 0;
    endtask

    // candidate mostly inside the image
    function automatic ftt_pkg::t_in cand_req();
        int xmax, ymax;
        xmax = int'(sb.img_w) * 16;
        ymax = int'(sb.img_h) * 16;
        if ($urandom_range(9) == 0) return noise_req(ftt_pkg::REQ_CAND);
        return make_req(ftt_pkg::REQ_CAND, $urandom_range(xmax), $urandom_range(ymax),
                        $urandom, $urandom, 1'($urandom), 1'($urandom));
    endfunction

    task automatic run_frame(int ncand);
        int n, sx, sy, px, py;
        n = sb.total;
        for (int i = 0; i < n; i++) begin
            sx = sb.x_tab[sb.rd_slot];
            sy = sb.y_tab[sb.rd_slot];
            px = sx + $signed($urandom_range(80)) - 40;
            py = sy + $signed($urandom_range(80)) - 40;
            case ($urandom_range(9))
                0: send(noise_req(ftt_pkg::REQ_TRACK));
                1: send(make_req(ftt_pkg::REQ_TRACK, px, py, sx + 5, sy - 5, 1, 1));
                2: send(make_req(ftt_pkg::REQ_TRACK, px, py, sx, sy,
                                 1'($urandom), 1'($urandom)));
                default: send(make_req(ftt_pkg::REQ_TRACK, px, py,
                    sx + $signed($urandom_range(6)) - 3,
                    sy + $signed($urandom_range(6)) - 3, 1, 1));
            endcase
        end
        if ($urandom_range(7) == 0) send(noise_req(ftt_pkg::REQ_TRACK));
        if ($urandom_range(9) == 0) send(cand_req());
        send(noise_req(ftt_pkg::REQ_PASS));
        for (int i = 0; i < ncand; i++) begin
            if ($urandom_range(19) == 0) send(noise_req(ftt_pkg::REQ_IGNORE));
            send(cand_req());
        end
    endtask

    task automatic random_phase(int budget, int mode);
        case (mode)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 54; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 54; end
            default: begin gap_pct = 11; stall_pct = 11; end
        endcase
        budget = sent + budget;
        while (sent < budget) run_frame($urandom_range(0, 12));
    endtask

    initial begin
        sb = new();
        sb.clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: cold start, extremes, extra tracked, unknown request
        send(make_req(ftt_pkg::REQ_CAND, 320 * 16, 240 * 16, 0, 0, 0, 0));
        send(make_req(ftt_pkg::REQ_CAND, 320 * 16 + 5, 240 * 16, 0, 0, 0, 0));
        send(make_req(ftt_pkg::REQ_CAND, 16'sh7fff, -32768, 16'sh7fff, -32768, 1, 1));
        send(make_req(ftt_pkg::REQ_CAND, 100 * 16, 100 * 16, -1, -1, 1, 1));
        send(make_req(ftt_pkg::REQ_CAND, 5 * 16, 30 * 16, 0, 0, 1, 1));
        send(make_req(ftt_pkg::REQ_CAND, 30 * 16, 30 * 16, 0, 0, 1, 1));
        send(make_req(ftt_pkg::REQ_IGNORE, -1, -1, -1, -1, 1, 1));
        send(make_req(ftt_pkg::REQ_PASS, 0, 0, 0, 0, 0, 0));
        send(make_req(ftt_pkg::REQ_CAND, 200 * 16, 200 * 16, 0, 0, 0, 0));
        send(make_req(ftt_pkg::REQ_PASS, 0, 0, 0, 0, 0, 0));
        send(make_req(ftt_pkg::REQ_TRACK, 320 * 16 + 30, 240 * 16,
                      320 * 16 + 3, 240 * 16 + 3, 1, 1));
        send(make_req(ftt_pkg::REQ_TRACK, 320 * 16, 240 * 16, 320 * 16, 240 * 16, 0, 1));
        send(make_req(ftt_pkg::REQ_TRACK, 16'sh7fff, 0, 16'sh7fff, -32768, 1, 0));
        send(make_req(ftt_pkg::REQ_TRACK, 100 * 16, 100 * 16,
                      100 * 16 + 4, 100 * 16 + 4, 1, 1));
        send(make_req(ftt_pkg::REQ_TRACK, 5 * 16, 30 * 16, 5 * 16, 30 * 16, 1, 1));
        send(make_req(ftt_pkg::REQ_TRACK, 30 * 16, 30 * 16, 30 * 16, 30 * 16, 1, 1));
        send(make_req(ftt_pkg::REQ_TRACK, 200 * 16 + 500, 200 * 16, 200 * 16, 200 * 16, 1, 1));
        send(make_req(ftt_pkg::REQ_TRACK, 0, 0, 0, 0, 1, 1));
        send(make_req(ftt_pkg::REQ_CAND, 400 * 16, 300 * 16, 0, 0, 0, 0));
        send(make_req(ftt_pkg::REQ_PASS, 0, 0, 0, 0, 1, 1));
        send(make_req(ftt_pkg::REQ_PASS, 0, 0, 0, 0, 1, 1));

        random_phase(110, 0);
        // receiver holds off while requests keep coming
        drain();
        hold_req = 1;
        gap_pct = 0;
        for (int i = 0; i < 12; i++) send(cand_req());

        configure(7'd64, 12'd0, 16'hffff, 12'd2048, 12'd2048);
        random_phase(140, 1);
        configure(7'd1, 12'd4095, 16'd0, 12'd1, 12'd1);
        random_phase(80, 2);
        configure(7'd0, 12'd16, 16'd100, 12'd100, 12'd100);
        random_phase(60, 3);
        configure(7'd127, 12'd40, 16'd900, 12'd320, 12'd240);
        random_phase(140, 0);
        configure(7'd3, 12'd2000, 16'd480, 12'd640, 12'd480);
        random_phase(80, 1);
        configure(ftt_pkg::RST_MAX_FEATURES, ftt_pkg::RST_MIN_SPACING,
                  ftt_pkg::RST_MAX_MOTION, ftt_pkg::RST_IMAGE_WIDTH,
                  ftt_pkg::RST_IMAGE_HEIGHT);
        for (int p = 0; p < 4; p++) random_phase(80, p);

        i_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
